FILE: hw/rtl/ssc_pkg.sv
// Shared types, widths and constants of the stick sample conditioner.
// No dependencies; every other file refers to this package by scoped names.
package ssc_pkg;

  // Samples averaged per pin before a result is produced (1..7).
  localparam int AVG_COUNT = 5;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 15;
  localparam int CNT_W    = 3;
  localparam int VALUE_W  = 10;
  localparam int DB_W     = 9;

  // Floor division by AVG_COUNT as a multiply by a rounded-up reciprocal.
  // The shift covers the sum width plus the divisor bits, which is exact
  // for every 15-bit sum.
  localparam int AVG_SHIFT = SUM_W + CNT_W;
  localparam int RECIP_W   = AVG_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'((2 ** AVG_SHIFT + AVG_COUNT - 1) / AVG_COUNT);

  // Scaling by 1000/4096: multiply by 1000, then split at bit 12.
  localparam int SCALE_W     = 10;
  localparam int FRAC_W      = 12;
  localparam int SCALED_W    = SAMPLE_W + SCALE_W;
  localparam logic [SCALE_W-1:0] SCALE_MUL = SCALE_W'(1000);

  // Mapped values span -30..1030 and are held signed.
  localparam int MAP_W = 12;
  localparam logic signed [MAP_W-1:0] FULL_SCALE   = 12'sd1000;
  localparam logic signed [MAP_W-1:0] PITCH_SPAN   = 12'sd1030;
  localparam logic signed [MAP_W-1:0] PITCH_OFFSET = 12'sd30;
  localparam logic signed [MAP_W-1:0] ROLL_OFFSET  = 12'sd10;
  localparam logic signed [MAP_W-1:0] CENTRE       = 12'sd500;
  localparam logic signed [MAP_W-1:0] AXIS_LO      = 12'sd100;
  localparam logic signed [MAP_W-1:0] AXIS_HI      = 12'sd900;
  localparam logic signed [MAP_W-1:0] THROTTLE_LO  = 12'sd0;
  localparam logic signed [MAP_W-1:0] THROTTLE_HI  = 12'sd1000;
  localparam logic [SCALE_W-1:0]      PITCH_OFFSET_Q = SCALE_W'(30);

  // Configuration register indexes.
  localparam logic [1:0] REG_STICK_MODE      = 2'd0;
  localparam logic [1:0] REG_CENTER_DEADBAND = 2'd1;
  localparam logic [1:0] REG_THROTTLE_DB     = 2'd2;

  localparam logic       MODE_AMERICAN = 1'b0;
  localparam logic       MODE_JAPANESE = 1'b1;

  localparam logic [DB_W-1:0] CENTER_DB_RESET   = DB_W'(50);
  localparam logic [DB_W-1:0] THROTTLE_DB_RESET = DB_W'(0);

  typedef enum logic [1:0] {
    PIN_THROTTLE = 2'd0,
    PIN_PITCH    = 2'd1,
    PIN_YAW      = 2'd2,
    PIN_ROLL     = 2'd3
  } pin_t;

  typedef enum logic [1:0] {
    AXIS_ROLL     = 2'd0,
    AXIS_PITCH    = 2'd1,
    AXIS_YAW      = 2'd2,
    AXIS_THROTTLE = 2'd3
  } axis_t;

  // A completed sum handed from the accumulator to the arithmetic back end.
  typedef struct packed {
    pin_t             pin;
    logic [SUM_W-1:0] sum;
  } acc_item_t;

  typedef struct packed {
    logic            stick_mode;
    logic [DB_W-1:0] center_deadband;
    logic [DB_W-1:0] throttle_deadband;
  } cfg_t;

endpackage

FILE: hw/rtl/ssc_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on ssc_pkg for the field widths.
interface ssc_sample_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    pin_channel;
  logic [ssc_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output pin_channel, output sample, input ready);
  modport sink   (input valid, input pin_channel, input sample, output ready);
endinterface

interface ssc_result_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    axis;
  logic [ssc_pkg::VALUE_W-1:0]   stick_value;

  modport source (output valid, output axis, output stick_value, input ready);
  modport sink   (input valid, input axis, input stick_value, output ready);
endinterface

FILE: hw/rtl/ssc_front.sv
// Front end: per-pin sum and count accumulation; pushes completed sums.
// Depends on ssc_pkg and ssc_sample_if.
module ssc_front (
  input  logic                clk,
  input  logic                rst,
  ssc_sample_if.sink          samples,
  output logic                push_valid,
  input  logic                push_ready,
  output ssc_pkg::acc_item_t  push_item
);

  logic [ssc_pkg::SUM_W-1:0] sample_sum   [4];
  logic [ssc_pkg::CNT_W-1:0] sample_count [4];
  logic                      accept;
  logic [ssc_pkg::SUM_W-1:0] sum_next;
  logic [ssc_pkg::CNT_W-1:0] count_next;
  logic                      done;

  // An item is taken whenever the queue has room for a possible result.
  assign samples.ready = push_ready;
  assign accept        = samples.valid && samples.ready;

  // Running total and count for the addressed pin.
  always_comb begin
    sum_next   = sample_sum[samples.pin_channel] +
                 ssc_pkg::SUM_W'(samples.sample);
    count_next = sample_count[samples.pin_channel] + ssc_pkg::CNT_W'(1);
    done       = (count_next == ssc_pkg::CNT_W'(ssc_pkg::AVG_COUNT));
  end

  assign push_valid    = accept && done;
  assign push_item.pin = ssc_pkg::pin_t'(samples.pin_channel);
  assign push_item.sum = sum_next;

  // The pin's accumulator restarts once its average is complete.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        sample_sum[i]   <= '0;
        sample_count[i] <= '0;
      end
    end else if (accept) begin
      if (done) begin
        sample_sum[samples.pin_channel]   <= '0;
        sample_count[samples.pin_channel] <= '0;
      end else begin
        sample_sum[samples.pin_channel]   <= sum_next;
        sample_count[samples.pin_channel] <= count_next;
      end
    end
  end

endmodule

FILE: hw/rtl/ssc_queue.sv
// Two-entry queue decoupling the accumulator from the arithmetic pipeline.
// Depends on ssc_pkg for the item type.
module ssc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  ssc_pkg::acc_item_t  push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output ssc_pkg::acc_item_t  pop_item
);

  ssc_pkg::acc_item_t entry [2];
  logic [1:0]         fill;
  logic               wr_ptr;
  logic               rd_ptr;
  logic               push;
  logic               pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/ssc_back.sv
// Back end: divide, scale, map, deadband and clamp, four register stages.
// Depends on ssc_pkg and ssc_result_if.
module ssc_back (
  input  logic                clk,
  input  logic                rst,
  input  ssc_pkg::cfg_t       cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  ssc_pkg::acc_item_t  pop_item,
  ssc_result_if.source        results
);

  logic                               advance;

  logic                               s1_valid;
  ssc_pkg::pin_t                      s1_pin;
  logic [ssc_pkg::PROD_W-1:0]         s1_prod;

  logic                               s2_valid;
  ssc_pkg::pin_t                      s2_pin;
  logic [ssc_pkg::SCALED_W-1:0]       s2_scaled;

  logic                               s3_valid;
  ssc_pkg::axis_t                     s3_axis;
  logic                               s3_thro;
  logic signed [ssc_pkg::MAP_W-1:0]   s3_value;

  logic                               out_valid;
  ssc_pkg::axis_t                     out_axis;
  logic [ssc_pkg::VALUE_W-1:0]        out_value;

  logic [ssc_pkg::SAMPLE_W-1:0]       avg;
  logic [ssc_pkg::SCALE_W-1:0]        whole;
  logic signed [ssc_pkg::MAP_W-1:0]   whole_s;
  logic signed [ssc_pkg::MAP_W-1:0]   frac_up;
  logic signed [ssc_pkg::MAP_W-1:0]   map_value;
  ssc_pkg::axis_t                     map_axis;
  logic                               map_thro;

  logic signed [ssc_pkg::MAP_W:0]     diff;
  logic [ssc_pkg::MAP_W:0]            mag;
  logic [ssc_pkg::DB_W-1:0]           db;
  logic signed [ssc_pkg::MAP_W-1:0]   banded;
  logic signed [ssc_pkg::MAP_W-1:0]   lo;
  logic signed [ssc_pkg::MAP_W-1:0]   hi;
  logic signed [ssc_pkg::MAP_W-1:0]   clamped;

  // The whole pipeline moves unless a finished item waits at the output.
  assign advance   = !out_valid || results.ready;
  assign pop_ready = advance;

  assign results.valid       = out_valid;
  assign results.axis        = out_axis;
  assign results.stick_value = out_value;

  assign avg = s1_prod[ssc_pkg::AVG_SHIFT +: ssc_pkg::SAMPLE_W];

  // Mode mapping on the scaled value; whole part and a round-up flag
  // give truncation toward zero for the subtracting cases.
  always_comb begin
    whole   = s2_scaled[ssc_pkg::FRAC_W +: ssc_pkg::SCALE_W];
    whole_s = ssc_pkg::MAP_W'(whole);
    frac_up = ssc_pkg::MAP_W'(|s2_scaled[ssc_pkg::FRAC_W-1:0]);
    map_value = whole_s;
    map_axis  = ssc_pkg::AXIS_YAW;
    map_thro  = 1'b0;
    unique case (s2_pin)
      ssc_pkg::PIN_THROTTLE: begin
        if (cfg.stick_mode == ssc_pkg::MODE_AMERICAN) begin
          map_value = ssc_pkg::FULL_SCALE - whole_s - frac_up;
          map_axis  = ssc_pkg::AXIS_THROTTLE;
          map_thro  = 1'b1;
        end else begin
          map_value = ssc_pkg::PITCH_SPAN - whole_s - frac_up;
          map_axis  = ssc_pkg::AXIS_PITCH;
        end
      end
      ssc_pkg::PIN_PITCH: begin
        if (cfg.stick_mode == ssc_pkg::MODE_AMERICAN) begin
          // Below zero the quotient truncates upwards.
          map_value = whole_s - ssc_pkg::PITCH_OFFSET +
                      ((whole < ssc_pkg::PITCH_OFFSET_Q) ? frac_up : '0);
          map_axis  = ssc_pkg::AXIS_PITCH;
        end else begin
          map_value = whole_s;
          map_axis  = ssc_pkg::AXIS_THROTTLE;
          map_thro  = 1'b1;
        end
      end
      ssc_pkg::PIN_YAW: begin
        map_value = whole_s;
        map_axis  = ssc_pkg::AXIS_YAW;
      end
      ssc_pkg::PIN_ROLL: begin
        map_value = whole_s + ssc_pkg::ROLL_OFFSET;
        map_axis  = ssc_pkg::AXIS_ROLL;
      end
      default: begin
        map_value = whole_s;
        map_axis  = ssc_pkg::AXIS_YAW;
      end
    endcase
  end

  // Deadband around the centre, then the axis clamp.
  always_comb begin
    db   = s3_thro ? cfg.throttle_deadband : cfg.center_deadband;
    diff = {s3_value[ssc_pkg::MAP_W-1], s3_value} - {1'b0, ssc_pkg::CENTRE};
    mag  = diff[ssc_pkg::MAP_W] ? (ssc_pkg::MAP_W+1)'(-diff)
                                : (ssc_pkg::MAP_W+1)'(diff);
    banded = (mag > (ssc_pkg::MAP_W+1)'(db)) ? s3_value : ssc_pkg::CENTRE;
    lo = s3_thro ? ssc_pkg::THROTTLE_LO : ssc_pkg::AXIS_LO;
    hi = s3_thro ? ssc_pkg::THROTTLE_HI : ssc_pkg::AXIS_HI;
    priority if (banded < lo) begin
      clamped = lo;
    end else if (banded > hi) begin
      clamped = hi;
    end else begin
      clamped = banded;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // Stage payloads: reciprocal multiply, scale multiply, map, condition.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pin    <= pop_item.pin;
      s1_prod   <= ssc_pkg::PROD_W'(pop_item.sum * ssc_pkg::AVG_RECIP);
      s2_pin    <= s1_pin;
      s2_scaled <= ssc_pkg::SCALED_W'(avg * ssc_pkg::SCALE_MUL);
      s3_axis   <= map_axis;
      s3_thro   <= map_thro;
      s3_value  <= map_value;
      out_axis  <= s3_axis;
      out_value <= clamped[ssc_pkg::VALUE_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/stick_sample_conditioner.sv
// Stick sample conditioner top level: configuration registers and wiring.
// Depends on ssc_pkg, ssc_if, ssc_front, ssc_queue and ssc_back.
//
// Accepts one pin-tagged 12-bit sample per clock and keeps a sum and count
// for each of the four pins; every fifth sample of a pin (AVG_COUNT) yields
// one result, its floor average scaled by 1000/4096, mapped by stick mode,
// deadbanded about 500 and clamped. A result passes through the queue and
// the arithmetic pipeline and stays on the output until taken. Throughput
// is one sample per cycle; the input stalls only when the two-entry queue
// between the accumulator and the four-stage arithmetic pipeline is full,
// which happens only while the output is held off. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must write it only while
// the block is idle, which the block does not enforce; index 3 is ignored.
module stick_sample_conditioner (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [ssc_pkg::DB_W-1:0] cfg_data,
  ssc_sample_if.sink               samples,
  ssc_result_if.source             results
);

  ssc_pkg::cfg_t      cfg;
  logic               push_valid;
  logic               push_ready;
  ssc_pkg::acc_item_t push_item;
  logic               pop_valid;
  logic               pop_ready;
  ssc_pkg::acc_item_t pop_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick_mode        <= ssc_pkg::MODE_AMERICAN;
      cfg.center_deadband   <= ssc_pkg::CENTER_DB_RESET;
      cfg.throttle_deadband <= ssc_pkg::THROTTLE_DB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssc_pkg::REG_STICK_MODE:      cfg.stick_mode        <= cfg_data[0];
        ssc_pkg::REG_CENTER_DEADBAND: cfg.center_deadband   <= cfg_data;
        ssc_pkg::REG_THROTTLE_DB:     cfg.throttle_deadband <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ssc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ssc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ssc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .results   (results)
  );

endmodule

FILE: hw/rtl/ssc_checker.sv
// Port-level checks on the conditioner output, bound to the top level.
// Depends on ssc_pkg and stick_sample_conditioner.
module ssc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_axis,
  input logic [ssc_pkg::VALUE_W-1:0] out_value
);

  // A result held off by the sink stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_axis) && $stable(out_value))
    else $error("result changed while stalled");

  // Nothing is offered straight after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // Every result stays within full scale.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_value <= ssc_pkg::VALUE_W'(1000))
    else $error("stick value above full scale");

  // Roll, pitch and yaw stay inside their clamp range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_axis != ssc_pkg::AXIS_THROTTLE |->
      out_value >= ssc_pkg::VALUE_W'(100) && out_value <= ssc_pkg::VALUE_W'(900))
    else $error("centred axis outside clamp range");

endmodule

bind stick_sample_conditioner ssc_checker u_ssc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_axis  (results.axis),
  .out_value (results.stick_value)
);
